FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks clocked on the rising edge, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every enabled edge
`define ASSERT_CHECK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// condition must never be true at an enabled edge
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CHECK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

FILE: sv/hbeg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbeg_pkg
// Shared types, codes and saturation helpers for the harmonic bath engine.
// ----------------------------------------------------------------------------
package hbeg_pkg;

  localparam int VAL_W = 48;             // Q24.24 result width
  localparam int SUM_W = VAL_W + 2;      // headroom for one add or a negate
  localparam int IN_W  = 32;             // Q8.24 input width
  localparam int FREQ_W = 31;            // unsigned frequency width
  localparam int CFG_IDX_W = 4;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  localparam logic [1:0] KIND_ELEC  = 2'd0;
  localparam logic [1:0] KIND_BATH  = 2'd1;
  localparam logic [1:0] KIND_TOTAL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PRIMARY_FREQUENCY = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIMARY_COUPLING  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIAS         = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TUNNEL_DELTA      = 4'd3;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_BATH,
    OP_PRIMARY
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic signed [IN_W-1:0]  position;
    logic [FREQ_W-1:0]       mode_frequency;
    logic signed [IN_W-1:0]  mode_coupling;
    logic                    last_mode;
  } q_entry_t;

  typedef struct packed {
    logic [FREQ_W-1:0]      primary_frequency;
    logic signed [IN_W-1:0] primary_coupling;
    logic signed [IN_W-1:0] half_bias;
    logic signed [IN_W-1:0] tunnel_delta;
  } cfg_regs_t;

  typedef struct packed {
    logic start;
    logic half;      // shift by one more bit for the halved products
  } mul_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [VAL_W-1:0] result;
  } mul_rsp_t;

  typedef enum logic [2:0] {
    MUL_IDLE,
    MUL_LO,
    MUL_HI,
    MUL_ADD,
    MUL_FIN
  } mul_phase_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ISSUE,
    BK_WAIT,
    BK_SUM,
    BK_ACC,
    BK_EMIT,
    BK_TOTAL
  } back_state_t;

  function automatic logic signed [SUM_W-1:0] ext_sum(input logic signed [VAL_W-1:0] v);
    return {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
  endfunction

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v[SUM_W-1:VAL_W-1] == {(SUM_W-VAL_W+1){1'b0}} ||
        v[SUM_W-1:VAL_W-1] == {(SUM_W-VAL_W+1){1'b1}}) begin
      r = v[VAL_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = VAL_MIN;
    end else begin
      r = VAL_MAX;
    end
    return r;
  endfunction

endpackage

FILE: sv/hbeg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbeg_front
// Input stage: takes items, tags primary versus bath mode, feeds the queue.
// ----------------------------------------------------------------------------
module hbeg_front import hbeg_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_is_primary,
  input  logic signed [IN_W-1:0]  in_position,
  input  logic [FREQ_W-1:0]       in_mode_frequency,
  input  logic signed [IN_W-1:0]  in_mode_coupling,
  input  logic                    in_last_mode,
  output logic                    push_valid,
  input  logic                    push_ready,
  output q_entry_t                push_data
);

  logic     valid_r, valid_nxt;
  q_entry_t ent_r;
  logic     take;

  assign in_ready   = !valid_r || push_ready;
  assign take       = in_valid && in_ready;
  assign push_valid = valid_r;
  assign push_data  = ent_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (push_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ent_r.op             <= in_is_primary ? OP_PRIMARY : OP_BATH;
      ent_r.position       <= in_position;
      ent_r.mode_frequency <= in_mode_frequency;
      ent_r.mode_coupling  <= in_mode_coupling;
      ent_r.last_mode      <= in_last_mode;
    end
  end

endmodule

FILE: sv/hbeg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbeg_queue
// Short FIFO between the front stage and the compute sequencer.
// ----------------------------------------------------------------------------
module hbeg_queue import hbeg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  q_entry_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output q_entry_t pop_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t         slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: sv/hbeg_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbeg_mul
// Shared fixed-point multiplier: sign-magnitude, two 24x32 partial products,
// round half away from zero, shift and saturate to 48 bits.
// ----------------------------------------------------------------------------
module hbeg_mul import hbeg_pkg::*; #(
  parameter int FRAC_BITS = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mul_req_t                req,
  input  logic signed [VAL_W-1:0] op_a,
  input  logic signed [IN_W-1:0]  op_b,
  output mul_rsp_t                rsp
);

  localparam int H_W  = VAL_W / 2;
  localparam int PP_W = H_W + IN_W;
  localparam int P_W  = VAL_W + IN_W + 1;
  localparam logic [P_W-1:0] RND_FULL = P_W'(1) << (FRAC_BITS - 1);
  localparam logic [P_W-1:0] RND_HALF = P_W'(1) << FRAC_BITS;

  mul_phase_t        phase_r, phase_nxt;
  logic [VAL_W-1:0]  mag_a_r;
  logic [IN_W-1:0]   mag_b_r;
  logic              neg_r, half_r;
  logic [PP_W-1:0]   lo_r, hi_r;
  logic [P_W-1:0]    sum_r;
  logic signed [VAL_W-1:0] res_r;
  logic              done_r;

  logic              ld_mag, ld_lo, ld_hi, ld_sum, ld_res;
  logic [P_W-1:0]    shifted;
  logic [VAL_W-1:0]  lim, mag_res;
  logic              over;

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      MUL_IDLE: if (req.start) phase_nxt = MUL_LO;
      MUL_LO:   phase_nxt = MUL_HI;
      MUL_HI:   phase_nxt = MUL_ADD;
      MUL_ADD:  phase_nxt = MUL_FIN;
      MUL_FIN:  phase_nxt = MUL_IDLE;
      default:  phase_nxt = MUL_IDLE;
    endcase
  end

  always_comb begin
    ld_mag = 1'b0;
    ld_lo  = 1'b0;
    ld_hi  = 1'b0;
    ld_sum = 1'b0;
    ld_res = 1'b0;
    unique case (phase_r)
      MUL_IDLE: ld_mag = req.start;
      MUL_LO:   ld_lo  = 1'b1;
      MUL_HI:   ld_hi  = 1'b1;
      MUL_ADD:  ld_sum = 1'b1;
      MUL_FIN:  ld_res = 1'b1;
      default:  ;
    endcase
  end

  // round-shift the magnitude, clamp to the signed limit, restore the sign
  always_comb begin
    shifted = half_r ? (sum_r >> (FRAC_BITS + 1)) : (sum_r >> FRAC_BITS);
    lim     = neg_r ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    over    = (|shifted[P_W-1:VAL_W]) || (shifted[VAL_W-1:0] > lim);
    mag_res = over ? lim : shifted[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= MUL_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= ld_res;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_mag) begin
      mag_a_r <= op_a[VAL_W-1] ? (~op_a + 1'b1) : op_a;
      mag_b_r <= op_b[IN_W-1] ? (~op_b + 1'b1) : op_b;
      neg_r   <= op_a[VAL_W-1] ^ op_b[IN_W-1];
      half_r  <= req.half;
    end
    if (ld_lo) begin
      lo_r <= PP_W'(mag_a_r[H_W-1:0]) * PP_W'(mag_b_r);
    end
    if (ld_hi) begin
      hi_r <= PP_W'(mag_a_r[VAL_W-1:H_W]) * PP_W'(mag_b_r);
    end
    if (ld_sum) begin
      sum_r <= P_W'(lo_r) + (P_W'(hi_r) << H_W) + (half_r ? RND_HALF : RND_FULL);
    end
    if (ld_res) begin
      res_r <= neg_r ? (~mag_res + 1'b1) : mag_res;
    end
  end

  assign rsp = '{done: done_r, result: res_r};

endmodule

FILE: sv/hbeg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbeg_back
// Compute sequencer: steps each item through the shared multiplier, updates
// the running sums and emits electronic, gradient and totals results.
// ----------------------------------------------------------------------------
module hbeg_back import hbeg_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_regs_t               cfg,
  input  logic                    q_valid,
  output logic                    q_ready,
  input  q_entry_t                q_data,
  output mul_req_t                mul_req,
  output logic signed [VAL_W-1:0] mul_a,
  output logic signed [IN_W-1:0]  mul_b,
  input  mul_rsp_t                mul_rsp,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_kind,
  output logic signed [VAL_W-1:0] out_value_a,
  output logic signed [VAL_W-1:0] out_value_b,
  output logic signed [VAL_W-1:0] out_value_c,
  output logic                    out_last_result
);

  localparam int STEPS  = 6;
  localparam int STEP_W = $clog2(STEPS);

  // primary item products
  localparam logic [STEP_W-1:0] ST_P_FREQ_SQ = 3'd0;  // W0^2
  localparam logic [STEP_W-1:0] ST_P_GRAD    = 3'd1;  // W0^2 * x0
  localparam logic [STEP_W-1:0] ST_P_ENERGY  = 3'd2;  // half of g0 * x0
  localparam logic [STEP_W-1:0] ST_P_DIAG    = 3'd3;  // coeff0 * x0
  // bath item products
  localparam logic [STEP_W-1:0] ST_B_FREQ_SQ = 3'd0;  // w^2
  localparam logic [STEP_W-1:0] ST_B_SPRING  = 3'd1;  // w^2 * x
  localparam logic [STEP_W-1:0] ST_B_CROSS   = 3'd2;  // c * x0
  localparam logic [STEP_W-1:0] ST_B_SPR_E   = 3'd3;  // half of w^2 x * x
  localparam logic [STEP_W-1:0] ST_B_CROSS_E = 3'd4;  // c x0 * x
  localparam logic [STEP_W-1:0] ST_B_PGRAD   = 3'd5;  // c * x

  back_state_t state_r, state_nxt;
  logic [STEP_W-1:0] step_r;
  q_entry_t    ent_r;
  logic signed [VAL_W-1:0] tmp_r [STEPS];
  logic signed [IN_W-1:0]  x0_r;
  logic signed [VAL_W-1:0] energy_r, pgrad_r;
  logic signed [VAL_W-1:0] res_a_r, res_b_r, e_r;

  logic                    out_valid_r, out_valid_nxt;
  logic [1:0]              out_kind_r;
  logic signed [VAL_W-1:0] out_a_r, out_b_r, out_c_r;
  logic                    out_last_r;

  logic out_free, last_step, is_prim;
  logic pop, sum_en, acc_en, emit_ld, total_ld;
  logic mul_start, mul_half;
  logic signed [SUM_W-1:0] diag, diag_neg;
  logic signed [VAL_W-1:0] delta_ext;

  assign out_free  = !out_valid_r || out_ready;
  assign is_prim   = (ent_r.op == OP_PRIMARY);
  assign last_step = is_prim ? (step_r == ST_P_DIAG) : (step_r == ST_B_PGRAD);
  assign delta_ext = {{(VAL_W-IN_W){cfg.tunnel_delta[IN_W-1]}}, cfg.tunnel_delta};
  assign mul_req   = '{start: mul_start, half: mul_half};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:  if (q_valid) state_nxt = BK_ISSUE;
      BK_ISSUE: state_nxt = BK_WAIT;
      BK_WAIT:  if (mul_rsp.done) state_nxt = last_step ? BK_SUM : BK_ISSUE;
      BK_SUM:   state_nxt = is_prim ? BK_EMIT : BK_ACC;
      BK_ACC:   state_nxt = BK_EMIT;
      BK_EMIT:  if (out_free) state_nxt = ent_r.last_mode ? BK_TOTAL : BK_IDLE;
      BK_TOTAL: if (out_free) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_ready   = 1'b0;
    pop       = 1'b0;
    sum_en    = 1'b0;
    acc_en    = 1'b0;
    emit_ld   = 1'b0;
    total_ld  = 1'b0;
    mul_start = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        q_ready = 1'b1;
        pop     = q_valid;
      end
      BK_ISSUE: mul_start = 1'b1;
      BK_SUM:   sum_en    = 1'b1;
      BK_ACC:   acc_en    = 1'b1;
      BK_EMIT:  emit_ld   = out_free;
      BK_TOTAL: total_ld  = out_free;
      default:  ;
    endcase
  end

  // operand select for the current product
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    mul_half = 1'b0;
    unique case (ent_r.op)
      OP_PRIMARY: begin
        unique case (step_r)
          ST_P_FREQ_SQ: begin
            mul_a = {{(VAL_W-FREQ_W){1'b0}}, cfg.primary_frequency};
            mul_b = {1'b0, cfg.primary_frequency};
          end
          ST_P_GRAD: begin
            mul_a = tmp_r[ST_P_FREQ_SQ];
            mul_b = ent_r.position;
          end
          ST_P_ENERGY: begin
            mul_a    = tmp_r[ST_P_GRAD];
            mul_b    = ent_r.position;
            mul_half = 1'b1;
          end
          ST_P_DIAG: begin
            mul_a = {{(VAL_W-IN_W){cfg.primary_coupling[IN_W-1]}}, cfg.primary_coupling};
            mul_b = ent_r.position;
          end
          default: ;
        endcase
      end
      OP_BATH: begin
        unique case (step_r)
          ST_B_FREQ_SQ: begin
            mul_a = {{(VAL_W-FREQ_W){1'b0}}, ent_r.mode_frequency};
            mul_b = {1'b0, ent_r.mode_frequency};
          end
          ST_B_SPRING: begin
            mul_a = tmp_r[ST_B_FREQ_SQ];
            mul_b = ent_r.position;
          end
          ST_B_CROSS: begin
            mul_a = {{(VAL_W-IN_W){ent_r.mode_coupling[IN_W-1]}}, ent_r.mode_coupling};
            mul_b = x0_r;
          end
          ST_B_SPR_E: begin
            mul_a    = tmp_r[ST_B_SPRING];
            mul_b    = ent_r.position;
            mul_half = 1'b1;
          end
          ST_B_CROSS_E: begin
            mul_a = tmp_r[ST_B_CROSS];
            mul_b = ent_r.position;
          end
          ST_B_PGRAD: begin
            mul_a = {{(VAL_W-IN_W){ent_r.mode_coupling[IN_W-1]}}, ent_r.mode_coupling};
            mul_b = ent_r.position;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign diag     = ext_sum({{(VAL_W-IN_W){cfg.half_bias[IN_W-1]}}, cfg.half_bias})
                  + ext_sum(tmp_r[ST_P_DIAG]);
  assign diag_neg = -diag;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_ld || total_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      x0_r        <= '0;
      energy_r    <= '0;
      pgrad_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        step_r <= '0;
      end else if (mul_rsp.done) begin
        step_r <= step_r + 1'b1;
      end
      if (sum_en) begin
        unique case (ent_r.op)
          OP_PRIMARY: begin
            // reload the sums for a new configuration
            x0_r     <= ent_r.position;
            pgrad_r  <= tmp_r[ST_P_GRAD];
            energy_r <= tmp_r[ST_P_ENERGY];
          end
          OP_BATH: pgrad_r <= sat_val(ext_sum(pgrad_r) + ext_sum(tmp_r[ST_B_PGRAD]));
          default: ;
        endcase
      end
      if (acc_en) begin
        energy_r <= sat_val(ext_sum(energy_r) + ext_sum(e_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ent_r <= q_data;
    end
    if (mul_rsp.done) begin
      tmp_r[step_r] <= mul_rsp.result;
    end
    if (sum_en) begin
      unique case (ent_r.op)
        OP_PRIMARY: begin
          res_a_r <= sat_val(diag);
          res_b_r <= sat_val(diag_neg);
        end
        OP_BATH: begin
          res_a_r <= sat_val(ext_sum(tmp_r[ST_B_SPRING]) + ext_sum(tmp_r[ST_B_CROSS]));
          res_b_r <= '0;
          e_r     <= sat_val(ext_sum(tmp_r[ST_B_SPR_E]) + ext_sum(tmp_r[ST_B_CROSS_E]));
        end
        default: ;
      endcase
    end
    if (emit_ld) begin
      out_kind_r <= is_prim ? KIND_ELEC : KIND_BATH;
      out_a_r    <= res_a_r;
      out_b_r    <= res_b_r;
      out_c_r    <= is_prim ? delta_ext : '0;
      out_last_r <= !ent_r.last_mode;
    end else if (total_ld) begin
      out_kind_r <= KIND_TOTAL;
      out_a_r    <= energy_r;
      out_b_r    <= pgrad_r;
      out_c_r    <= '0;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_value_a     = out_a_r;
  assign out_value_b     = out_b_r;
  assign out_value_c     = out_c_r;
  assign out_last_result = out_last_r;

endmodule

FILE: sv/harmonic_bath_energy_gradient.sv
// Each item passes through the compute sequencer one product at a time; an item flagged
// last is followed by a totals result.
// The single shared multiplier serialises the work: a new item is taken only after the last is emitted.
// Each product runs issue, two partial products, add, round, hand-back.
// Reset (rst_n low, synchronous) clears registers, sums, held x0 and the queue.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// harmonic_bath_energy_gradient
// Spin-boson harmonic bath energy and gradient engine: front stage, queue,
// compute sequencer and shared multiplier, with the configuration registers.
// ----------------------------------------------------------------------------
module harmonic_bath_energy_gradient import hbeg_pkg::*; #(
  parameter int FRAC_BITS = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [IN_W-1:0]         cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_is_primary,
  input  logic signed [IN_W-1:0]  in_position,
  input  logic [FREQ_W-1:0]       in_mode_frequency,
  input  logic signed [IN_W-1:0]  in_mode_coupling,
  input  logic                    in_last_mode,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_kind,
  output logic signed [VAL_W-1:0] out_value_a,
  output logic signed [VAL_W-1:0] out_value_b,
  output logic signed [VAL_W-1:0] out_value_c,
  output logic                    out_last_result
);

  cfg_regs_t cfg_r;
  logic      push_valid, push_ready, pop_valid, pop_ready;
  q_entry_t  push_data, pop_data;
  mul_req_t  mul_req;
  mul_rsp_t  mul_rsp;
  logic signed [VAL_W-1:0] mul_a;
  logic signed [IN_W-1:0]  mul_b;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PRIMARY_FREQUENCY: cfg_r.primary_frequency <= cfg_data[FREQ_W-1:0];
        CFG_PRIMARY_COUPLING:  cfg_r.primary_coupling  <= cfg_data;
        CFG_HALF_BIAS:         cfg_r.half_bias         <= cfg_data;
        CFG_TUNNEL_DELTA:      cfg_r.tunnel_delta      <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  hbeg_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_is_primary     (in_is_primary),
    .in_position       (in_position),
    .in_mode_frequency (in_mode_frequency),
    .in_mode_coupling  (in_mode_coupling),
    .in_last_mode      (in_last_mode),
    .push_valid        (push_valid),
    .push_ready        (push_ready),
    .push_data         (push_data)
  );

  hbeg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  hbeg_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .rsp   (mul_rsp)
  );

  hbeg_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (pop_valid),
    .q_ready         (pop_ready),
    .q_data          (pop_data),
    .mul_req         (mul_req),
    .mul_a           (mul_a),
    .mul_b           (mul_b),
    .mul_rsp         (mul_rsp),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_value_a     (out_value_a),
    .out_value_b     (out_value_b),
    .out_value_c     (out_value_c),
    .out_last_result (out_last_result)
  );

  // a first result that is not final must be followed right away by the totals
  `ASSERT_CHECK(a_totals_follow, clk, rst_n, out_valid && out_ready && !out_last_result |=> out_valid && out_kind == KIND_TOTAL)
  `ASSERT_CHECK(a_totals_last, clk, rst_n, out_valid && out_kind == KIND_TOTAL |-> out_last_result && out_value_c == '0)
  `ASSERT_NEVER(a_bath_clean, clk, rst_n, out_valid && out_kind == KIND_BATH && (out_value_b != '0 || out_value_c != '0))

endmodule
